@@ rtl/olf_pkg.sv @@
// Shared types and character codes for the overstrike-to-underline line filter.
// No dependencies; imported by every module of the block except olf_line_mem.
`default_nettype none

package olf_pkg;

  // Default line store width in columns
  localparam int LINE_WIDTH_DEF = 132;

  // Bytes carried in one output transfer
  localparam int CHUNK_BYTES = 8;

  // Depth of the operation queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Character codes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_UL  = 8'h5F;

  // Operations handed from the front to the back
  typedef enum logic [2:0] {
    OP_ECHO,
    OP_BS,
    OP_TAB,
    OP_CHAR,
    OP_EOL
  } olf_op_t;

  typedef struct packed {
    olf_op_t    op;
    logic [7:0] data;
  } olf_item_t;

endpackage

`default_nettype wire

@@ rtl/olf_front.sv @@
// Front end: takes input bytes, tracks line mode and classifies each byte
// into an operation for the queue. Depends on olf_pkg.
`default_nettype none

module olf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_text_byte,
  output logic              push_valid,
  output olf_pkg::olf_item_t push_item,
  input  logic              push_ready
);
  import olf_pkg::*;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_PASS,
    MODE_BUILD
  } mode_t;

  mode_t mode_r, mode_nxt;
  logic  acc;

  // Input transfer; zero bytes are taken and dropped
  assign in_stall = !push_ready;
  assign acc      = in_valid && push_ready && (in_text_byte != CH_NUL);

  // Classify byte and work out the next mode
  always_comb begin
    mode_nxt       = mode_r;
    push_item.data = in_text_byte;
    push_item.op   = OP_CHAR;
    unique case (mode_r) inside
      MODE_START, MODE_BUILD: begin
        if (mode_r == MODE_START && in_text_byte == CH_BS) begin
          push_item.op = OP_ECHO;
          mode_nxt     = MODE_PASS;
        end else begin
          mode_nxt = MODE_BUILD;
          case (in_text_byte)
            CH_BS:   push_item.op = OP_BS;
            CH_TAB:  push_item.op = OP_TAB;
            CH_LF: begin
              push_item.op = OP_EOL;
              mode_nxt     = MODE_START;
            end
            default: push_item.op = OP_CHAR;
          endcase
        end
      end
      MODE_PASS: begin
        push_item.op = OP_ECHO;
        if (in_text_byte == CH_LF) begin
          mode_nxt = MODE_START;
        end
      end
      default: begin
        push_item.op = OP_CHAR;
      end
    endcase
  end

  assign push_valid = acc;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_START;
    end else if (acc) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/olf_queue.sv @@
// Short operation queue between front and back, so each side stalls on its own.
// Depends on olf_pkg for the item type and depth.
`default_nettype none

module olf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  olf_pkg::olf_item_t push_item,
  output logic               push_ready,
  output logic               pop_valid,
  output olf_pkg::olf_item_t pop_item,
  input  logic               pop_ready
);
  import olf_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  olf_item_t       entry_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/olf_line_mem.sv @@
// Main line store: rows of eight character cells, byte-masked write, registered read.
// No package dependencies.
`default_nettype none

module olf_line_mem #(
  parameter int ROWS = 17,
  parameter int AW   = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_row,
  input  logic [7:0]    wr_mask,
  input  logic [63:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_row,
  output logic [63:0]   rd_data
);

  logic [63:0] mem [ROWS];
  logic [63:0] rd_data_r;

  // Byte-masked write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int j = 0; j < 8; j++) begin
        if (wr_mask[j]) begin
          mem[wr_row][8*j +: 8] <= wr_data[8*j +: 8];
        end
      end
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/olf_back.sv @@
// Back end: carries out queued operations on the line store and emits chunks.
// Depends on olf_pkg; instantiates olf_line_mem.
`default_nettype none

module olf_back #(
  parameter int LINE_WIDTH = olf_pkg::LINE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  olf_pkg::olf_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_bytes,
  output logic [3:0]         out_byte_count,
  output logic               out_last_chunk
);
  import olf_pkg::*;

  localparam int ROWS = (LINE_WIDTH + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int RW   = $clog2(ROWS + 1);
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PADW = (ROWS + 1) * CHUNK_BYTES;
  localparam logic [8:0] LW9      = 9'(LINE_WIDTH);
  localparam logic [7:0] LAST_COL = 8'(LINE_WIDTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHAR,
    S_ERD,
    S_EOUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [7:0]      col_r, col_nxt;
  logic [7:0]      far_r, far_nxt;
  logic [7:0]      ext_r, ext_nxt;
  logic [7:0]      pend_r, pend_nxt;
  logic [PADW-1:0] vld_r, vld_nxt;
  logic [PADW-1:0] mark_r, mark_nxt;
  logic [PADW-1:0] in_range;
  logic [RW-1:0]   row_r, row_nxt;
  logic            ul_ph_r, ul_ph_nxt;
  logic [7:0]      cur_r, cur_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [63:0]     out_bytes_r, out_bytes_nxt;
  logic [3:0]      out_cnt_r, out_cnt_nxt;
  logic            out_last_r, out_last_nxt;

  // Line store port
  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_row, rd_row;
  logic [7:0]      wr_mask;
  logic [63:0]     wr_data;
  logic [63:0]     rd_data;

  // Column arithmetic
  logic [RW-1:0]   col_row;
  logic [2:0]      col_lane;
  logic [7:0]      lane_hot, tab_mask;
  logic [8:0]      col_p1, tab_end;
  logic [7:0]      adv_col, tab_col;
  logic [7:0]      vrow_col;
  logic [7:0]      stored;
  logic            do_mark, do_write;

  // Chunk assembly
  logic [RW+2:0]   base;
  logic [8:0]      base9, rem, pos;
  logic [7:0]      ncells, term, crow_v, crow_m;
  logic [63:0]     chunk;
  logic            chunk_last;
  logic [3:0]      chunk_cnt;
  logic            out_free;

  olf_line_mem #(
    .ROWS (ROWS),
    .AW   (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_row  (wr_row),
    .wr_mask (wr_mask),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_row  (rd_row),
    .rd_data (rd_data)
  );

  // Cells that exist in the padded flag vectors
  always_comb begin
    for (int i = 0; i < PADW; i++) begin
      in_range[i] = (i < LINE_WIDTH);
    end
  end

  // Current column: row, lane, next column after a write or a tab
  always_comb begin
    col_row  = RW'(col_r >> 3);
    col_lane = col_r[2:0];
    lane_hot = 8'b1 << col_lane;
    tab_mask = 8'hFF << col_lane;
    col_p1   = {1'b0, col_r} + 9'd1;
    adv_col  = (col_p1 >= LW9) ? LAST_COL : col_p1[7:0];
    tab_end  = {1'b0, col_r[7:3], 3'b000} + 9'd8;
    tab_col  = (tab_end >= LW9) ? LAST_COL : tab_end[7:0];
    vrow_col = vld_r[{col_row, 3'b000} +: 8];
    stored   = vrow_col[col_lane] ? rd_data[{col_lane, 3'b000} +: 8] : CH_NUL;
    do_mark  = (cur_r == CH_UL) || (cur_r == stored) || (stored == CH_UL);
    do_write = !((cur_r == CH_UL) || (cur_r == stored));
  end

  // One output chunk of the main or underline line
  always_comb begin
    base       = {row_r, 3'b000};
    base9      = 9'(base);
    ncells     = ul_ph_r ? ext_r : far_r;
    rem        = {1'b0, ncells} + 9'd1 - base9;
    chunk_last = (rem <= 9'd8);
    chunk_cnt  = chunk_last ? rem[3:0] : 4'd8;
    term       = (ul_ph_r || ext_r == 8'd0) ? CH_LF : CH_CR;
    crow_v     = vld_r[base +: 8];
    crow_m     = mark_r[base +: 8];
    for (int j = 0; j < 8; j++) begin
      pos = base9 + 9'(j);
      if (pos < {1'b0, ncells}) begin
        if (ul_ph_r) begin
          chunk[8*j +: 8] = crow_m[j] ? CH_UL : CH_SP;
        end else begin
          chunk[8*j +: 8] = crow_v[j] ? rd_data[8*j +: 8] : CH_NUL;
        end
      end else if (pos == {1'b0, ncells}) begin
        chunk[8*j +: 8] = term;
      end else begin
        chunk[8*j +: 8] = CH_NUL;
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    far_nxt       = far_r;
    ext_nxt       = ext_r;
    pend_nxt      = pend_r;
    vld_nxt       = vld_r;
    mark_nxt      = mark_r;
    row_nxt       = row_r;
    ul_ph_nxt     = ul_ph_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_bytes_nxt = out_bytes_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_row        = col_row[AW-1:0];
    wr_mask       = lane_hot;
    wr_data       = {8{q_item.data}};
    rd_en         = 1'b0;
    rd_row        = col_row[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            OP_ECHO: begin
              if (out_free) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                out_bytes_nxt = {56'd0, q_item.data};
                out_cnt_nxt   = 4'd1;
                out_last_nxt  = 1'b1;
              end
            end
            OP_BS: begin
              q_pop = 1'b1;
              if (col_r != 8'd0) begin
                col_nxt = col_r - 8'd1;
                if (pend_r != 8'hFF) begin
                  pend_nxt = pend_r + 8'd1;
                end
              end
            end
            OP_TAB: begin
              q_pop   = 1'b1;
              wr_en   = 1'b1;
              wr_mask = tab_mask;
              wr_data = {8{CH_SP}};
              vld_nxt[{col_row, 3'b000} +: 8] = vrow_col | tab_mask;
              vld_nxt = vld_nxt & in_range;
              col_nxt = tab_col;
              far_nxt = (tab_col > far_r) ? tab_col : far_r;
            end
            OP_CHAR: begin
              q_pop = 1'b1;
              if (pend_r == 8'd0) begin
                wr_en   = 1'b1;
                vld_nxt[{col_row, 3'b000} +: 8] = vrow_col | lane_hot;
                vld_nxt = vld_nxt & in_range;
                col_nxt = adv_col;
                far_nxt = (adv_col > far_r) ? adv_col : far_r;
              end else begin
                // overstrike: fetch the stored cell first
                rd_en     = 1'b1;
                cur_nxt   = q_item.data;
                state_nxt = S_CHAR;
              end
            end
            OP_EOL: begin
              q_pop     = 1'b1;
              row_nxt   = '0;
              ul_ph_nxt = 1'b0;
              state_nxt = S_ERD;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end

      S_CHAR: begin
        if (do_mark) begin
          mark_nxt[{col_row, 3'b000} +: 8] = mark_r[{col_row, 3'b000} +: 8] | lane_hot;
          mark_nxt = mark_nxt & in_range;
          ext_nxt  = (col_p1[7:0] > ext_r) ? col_p1[7:0] : ext_r;
        end
        if (do_write) begin
          wr_en   = 1'b1;
          wr_data = {8{cur_r}};
          vld_nxt[{col_row, 3'b000} +: 8] = vrow_col | lane_hot;
          vld_nxt = vld_nxt & in_range;
        end
        pend_nxt  = pend_r - 8'd1;
        col_nxt   = adv_col;
        far_nxt   = (adv_col > far_r) ? adv_col : far_r;
        state_nxt = S_IDLE;
      end

      S_ERD: begin
        rd_en     = !ul_ph_r;
        rd_row    = row_r[AW-1:0];
        state_nxt = S_EOUT;
      end

      S_EOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bytes_nxt = chunk;
          out_cnt_nxt   = chunk_cnt;
          out_last_nxt  = 1'b0;
          if (!chunk_last) begin
            row_nxt   = row_r + 1'b1;
            state_nxt = S_ERD;
          end else if (!ul_ph_r && ext_r != 8'd0) begin
            ul_ph_nxt = 1'b1;
            row_nxt   = '0;
            state_nxt = S_ERD;
          end else begin
            // line done: clear both stores and the counters
            out_last_nxt = 1'b1;
            col_nxt      = 8'd0;
            far_nxt      = 8'd0;
            ext_nxt      = 8'd0;
            pend_nxt     = 8'd0;
            vld_nxt      = '0;
            mark_nxt     = '0;
            state_nxt    = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= 8'd0;
      far_r       <= 8'd0;
      ext_r       <= 8'd0;
      pend_r      <= 8'd0;
      vld_r       <= '0;
      mark_r      <= '0;
      row_r       <= '0;
      ul_ph_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      far_r       <= far_nxt;
      ext_r       <= ext_nxt;
      pend_r      <= pend_nxt;
      vld_r       <= vld_nxt;
      mark_r      <= mark_nxt;
      row_r       <= row_nxt;
      ul_ph_r     <= ul_ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_bytes      = out_bytes_r;
  assign out_byte_count = out_cnt_r;
  assign out_last_chunk = out_last_r;

endmodule

`default_nettype wire

@@ rtl/overstrike_to_underline_line_filter_top.sv @@
// Top level of the overstrike-to-underline line filter.
// Depends on olf_pkg; instantiates olf_front, olf_queue and olf_back.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  in_text_byte[7:0]
//   out_     output     out_valid/out_stall  out_bytes[63:0], out_byte_count[3:0],
//                                            out_last_chunk
//
// Plain bytes, backspaces, tabs and pass-through echoes finish in S_IDLE, an echo
// once the output register is free; a byte struck over a pending backspace
// reads the row, then writes it in S_CHAR. Line end, per chunk, reads the row
// in S_ERD (main line only), then loads the output in S_EOUT, up to 34 chunks.
// A four-entry queue separates front and back; in_stall rises when it is full.
// Reset is synchronous; cell valid bits and marks clear at once, no clearing pass.
// A stalled output transfer holds in the output register.
`default_nettype none

module overstrike_to_underline_line_filter_top #(
  parameter int LINE_WIDTH = olf_pkg::LINE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_last_chunk
);
  import olf_pkg::*;

  logic      push_valid, push_ready;
  olf_item_t push_item;
  logic      pop_valid, pop_ready;
  olf_item_t pop_item;

  // Classification front end
  olf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .push_valid   (push_valid),
    .push_item    (push_item),
    .push_ready   (push_ready)
  );

  // Operation queue
  olf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // Line store and emission back end
  olf_back #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (pop_valid),
    .q_item         (pop_item),
    .q_pop          (pop_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bytes      (out_bytes),
    .out_byte_count (out_byte_count),
    .out_last_chunk (out_last_chunk)
  );

endmodule

`default_nettype wire

@@ rtl/olf_checker.sv @@
// Port-level checks for the line filter, bound to the top level.
// Depends on olf_pkg for character codes.
`default_nettype none

module olf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_bytes,
  input logic [3:0]  out_byte_count,
  input logic        out_last_chunk
);
  import olf_pkg::*;

  logic [7:0] tail_byte;

  // Final byte of the current transfer
  assign tail_byte = 8'(out_bytes >> {out_byte_count - 4'd1, 3'b000});

  // Nothing is offered straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled transfer holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bytes)
      && $stable(out_byte_count) && $stable(out_last_chunk))
    else $error("stalled output transfer changed");

  // Count in range and unused bytes zero
  a_count_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_count != 4'd0 && out_byte_count <= 4'd8
      && (out_bytes >> {out_byte_count, 3'b000}) == 64'd0)
    else $error("bad byte count or padding");

  // A short chunk that is not final closes the main line with carriage return
  a_short_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_chunk && out_byte_count != 4'd8 |-> tail_byte == CH_CR)
    else $error("short non-final chunk without carriage return");

endmodule

bind overstrike_to_underline_line_filter_top olf_checker u_olf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_bytes      (out_bytes),
  .out_byte_count (out_byte_count),
  .out_last_chunk (out_last_chunk)
);

`default_nettype wire
